### rtl/cars_pkg.sv
// ----------------------------------------------------------------------------
// cars_pkg: shared types and constants for the cave automaton row step
// Row width, queue entry and register map used by the top level and its front, queue and back.
// ----------------------------------------------------------------------------
package cars_pkg;

   localparam int ROW_CELLS   = 64;
   localparam int CNT_W       = 4;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   typedef logic [ROW_CELLS-1:0] row_type;
   typedef logic [6:0]           width_type;
   typedef logic [CNT_W-1:0]     limit_type;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_ROW_WIDTH   = 2'd0,
      REG_DEATH_LIMIT = 2'd1,
      REG_BIRTH_LIMIT = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   localparam width_type RESET_ROW_WIDTH   = 7'd64;
   localparam limit_type RESET_DEATH_LIMIT = 4'd4;
   localparam limit_type RESET_BIRTH_LIMIT = 4'd4;

   typedef struct packed {
      width_type row_width;
      limit_type death_limit;
      limit_type birth_limit;
   } cfg_type;

   // one accepted row with the neighbourhood it needs
   typedef struct packed {
      row_type above;
      row_type mid;
      row_type row;
      logic    held;
      logic    last;
   } job_type;

endpackage

### rtl/cars_front.sv
// ----------------------------------------------------------------------------
// cars_front: request intake
// Keeps the row above and the held row and pushes one job per request.
// ----------------------------------------------------------------------------
module cars_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cars_pkg::row_type req_tdata,
   input  logic              req_tlast,
   output logic              push_valid,
   input  logic              push_ready,
   output cars_pkg::job_type push_data
);

   cars_pkg::row_type above_ff, above_in;
   cars_pkg::row_type current_ff, current_in;
   logic              held_ff, held_in;
   logic              take;

   assign req_tready = push_ready;
   assign take       = req_tvalid & push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data.above = above_ff;
      push_data.mid   = current_ff;
      push_data.row   = req_tdata;
      push_data.held  = held_ff;
      push_data.last  = req_tlast;
   end

   always_comb begin
      above_in   = above_ff;
      current_in = current_ff;
      held_in    = held_ff;
      if (take) begin
         if (req_tlast) begin
            above_in   = '1;
            current_in = '0;
            held_in    = 1'b0;
         end else begin
            if (held_ff) begin
               above_in = current_ff;
            end
            current_in = req_tdata;
            held_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff   <= '1;
         current_ff <= '0;
         held_ff    <= 1'b0;
      end else begin
         above_ff   <= above_in;
         current_ff <= current_in;
         held_ff    <= held_in;
      end
   end

endmodule

### rtl/cars_queue.sv
// ----------------------------------------------------------------------------
// cars_queue: two-entry job queue
// Decouples request intake from result generation.
// ----------------------------------------------------------------------------
module cars_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cars_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cars_pkg::job_type pop_data
);

   cars_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop & ~push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/cars_back.sv
// ----------------------------------------------------------------------------
// cars_back: generation update and result register
// Applies the neighbour-count rule to all cells of a row in parallel.
// ----------------------------------------------------------------------------
module cars_back (
   input  logic              clock,
   input  logic              reset,
   input  cars_pkg::cfg_type cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cars_pkg::job_type pop_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output cars_pkg::row_type rsp_tdata,
   output logic              rsp_tlast
);

   logic              phase_ff, phase_in;
   logic              valid_ff, valid_in;
   cars_pkg::row_type data_ff, data_in;
   logic              last_ff, last_in;

   logic              load_ok, second, emit;
   cars_pkg::row_type src_a, src_c, src_b, next_row;

   assign load_ok = ~valid_ff | rsp_tready;
   assign second  = phase_ff | ~pop_data.held;
   assign emit    = pop_data.held | pop_data.last;

   always_comb begin
      if (second) begin
         src_a = pop_data.held ? pop_data.mid : pop_data.above;
         src_c = pop_data.row;
         src_b = '1;
      end else begin
         src_a = pop_data.above;
         src_c = pop_data.mid;
         src_b = pop_data.row;
      end
   end

   always_comb begin
      cars_pkg::row_type    mask, a, c, b;
      logic [7:0]           nb;
      logic [cars_pkg::CNT_W-1:0] cnt;
      for (int i = 0; i < cars_pkg::ROW_CELLS; i++) begin
         mask[i] = (7'(i) < cfg.row_width);
      end
      a = src_a | ~mask;
      c = src_c | ~mask;
      b = src_b | ~mask;
      next_row = '0;
      for (int i = 0; i < cars_pkg::ROW_CELLS; i++) begin
         nb[0] = (i == 0) ? 1'b1 : a[(i == 0) ? 0 : i-1];
         nb[1] = a[i];
         nb[2] = (i == cars_pkg::ROW_CELLS-1) ? 1'b1 : a[(i == cars_pkg::ROW_CELLS-1) ? i : i+1];
         nb[3] = (i == 0) ? 1'b1 : c[(i == 0) ? 0 : i-1];
         nb[4] = (i == cars_pkg::ROW_CELLS-1) ? 1'b1 : c[(i == cars_pkg::ROW_CELLS-1) ? i : i+1];
         nb[5] = (i == 0) ? 1'b1 : b[(i == 0) ? 0 : i-1];
         nb[6] = b[i];
         nb[7] = (i == cars_pkg::ROW_CELLS-1) ? 1'b1 : b[(i == cars_pkg::ROW_CELLS-1) ? i : i+1];
         cnt = '0;
         for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, nb[k]};
         end
         if (c[i]) begin
            next_row[i] = (cnt >= cfg.death_limit);
         end else begin
            next_row[i] = (cnt > cfg.birth_limit);
         end
      end
      next_row = next_row & mask;
   end

   // a job with neither a held row nor the last flag produces nothing
   always_comb begin
      pop_ready = 1'b0;
      phase_in  = phase_ff;
      valid_in  = valid_ff & ~rsp_tready;
      data_in   = data_ff;
      last_in   = last_ff;
      if (pop_valid) begin
         if (!emit) begin
            pop_ready = 1'b1;
         end else if (load_ok) begin
            valid_in = 1'b1;
            data_in  = next_row;
            last_in  = second;
            if (!second && pop_data.last) begin
               phase_in = 1'b1;
            end else begin
               phase_in  = 1'b0;
               pop_ready = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/cave_automaton_row_step.sv
// ----------------------------------------------------------------------------
// cave_automaton_row_step: one generation of a binary cave automaton per row
// An accepted row is registered in the job queue and then in the result register.
// One request per cycle unless the job queue is full; a final row after a held row gives two results.
// A two-entry job queue sits between intake and the result register.
// Reset: row above all wall, no row held, queue empty, registers at defaults.
// ----------------------------------------------------------------------------
module cave_automaton_row_step (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [63:0]                          req_tdata,   // row_cells[63:0]
   input  logic                                 req_tlast,   // final_row
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [63:0]                          rsp_tdata,   // next_row_cells[63:0]
   output logic                                 rsp_tlast,   // grid_done
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cars_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cars_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cars_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   cars_pkg::cfg_type     cfg_ff, cfg_in;
   cars_pkg::reg_index_type csr_index;
   logic                  csr_write;

   logic                  push_valid, push_ready, pop_valid, pop_ready;
   cars_pkg::job_type     push_data, pop_data;

   assign csr_pready = 1'b1;
   assign csr_index  = cars_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            cars_pkg::REG_ROW_WIDTH:   cfg_in.row_width   = csr_pwdata[6:0];
            cars_pkg::REG_DEATH_LIMIT: cfg_in.death_limit = csr_pwdata[3:0];
            cars_pkg::REG_BIRTH_LIMIT: cfg_in.birth_limit = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cars_pkg::REG_ROW_WIDTH:   csr_prdata = {25'd0, cfg_ff.row_width};
         cars_pkg::REG_DEATH_LIMIT: csr_prdata = {28'd0, cfg_ff.death_limit};
         cars_pkg::REG_BIRTH_LIMIT: csr_prdata = {28'd0, cfg_ff.birth_limit};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width   <= cars_pkg::RESET_ROW_WIDTH;
         cfg_ff.death_limit <= cars_pkg::RESET_DEATH_LIMIT;
         cfg_ff.birth_limit <= cars_pkg::RESET_BIRTH_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cars_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cars_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cars_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
